FILE: rtl/core/nearest_source_voice_select_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest source voice select block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SOURCE_VOICE_SELECT_DEFINES_SVH
`define NEAREST_SOURCE_VOICE_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define NSVS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("nsvs: assertion failed");
// A consequent that must hold in the same cycle as its antecedent.
`define NSVS_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nsvs: implication failed");
// A consequent that must hold in the cycle after its antecedent.
`define NSVS_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nsvs: next-cycle implication failed");
`else
`define NSVS_ASSERT(lbl, clk, rst_n, prop)
`define NSVS_IMPLY(lbl, clk, rst_n, ante, cons)
`define NSVS_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/nsvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsvs_pkg
// Shared constants, item types and helpers of the voice select block.
// ----------------------------------------------------------------------------
package nsvs_pkg;

	localparam int MAX_SLOTS = 32;
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	localparam int DIST_W = 34;
	localparam int RPM_W = 10;
	localparam int COORD_W = 16;
	localparam int CFG_W = 6;
	localparam int SLOT_OUT_W = 5;
	localparam int VOL_W = 7;
	localparam int FREQ_W = 18;

	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [DIST_W-1:0] FAR_RESET = DIST_W'(8196 * 8196);
	localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = CFG_W'(4);

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef logic [2:0][COORD_W-1:0] vec3_t;

	typedef struct packed {
		logic op;
		logic [RPM_W-1:0] rpm;
		vec3_t pos;
		vec3_t vel;
		logic [DIST_W-1:0] sq_dist;
	} cmd_t;

	typedef struct packed {
		logic [RPM_W-1:0] rpm;
		vec3_t pos;
		vec3_t vel;
	} entry_t;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic [RPM_W-1:0] rpm;
		vec3_t pos;
		vec3_t vel;
		logic [VOL_W-1:0] volume;
		logic [FREQ_W-1:0] freq;
		logic present;
		logic last;
	} res_t;

	// Number of slots in use, limited to the storage that exists.
	function automatic logic [CNT_W-1:0] capacity(input logic [CFG_W-1:0] count);
		if (int'(count) < MAX_SLOTS) begin
			return CNT_W'(count);
		end
		return CNT_W'(MAX_SLOTS);
	endfunction

endpackage

FILE: rtl/core/nsvs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsvs_front
// Accepts input items and forms the squared listener distance of an add.
// ----------------------------------------------------------------------------
module nsvs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [9:0]           engine_rpm,
	input  logic signed [15:0]   src_x,
	input  logic signed [15:0]   src_y,
	input  logic signed [15:0]   src_z,
	input  logic signed [15:0]   src_vx,
	input  logic signed [15:0]   src_vy,
	input  logic signed [15:0]   src_vz,
	input  logic signed [15:0]   lis_x,
	input  logic signed [15:0]   lis_y,
	input  logic signed [15:0]   lis_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output nsvs_pkg::cmd_t       out_cmd
);
	import nsvs_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQUARE = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;
	localparam logic [1:0] LAST_TERM = 2'd2;

	logic [1:0] state_q;
	logic [1:0] term_q;
	logic signed [COORD_W:0] diff_q [3];
	logic [DIST_W-1:0] acc_q;
	cmd_t cmd_q;
	logic signed [COORD_W:0] sq_op;
	logic signed [2*(COORD_W+1)-1:0] sq_prod;
	logic accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = (state_q == ST_PUSH);

	always_comb begin
		out_cmd = cmd_q;
		out_cmd.sq_dist = acc_q;
	end

	// One axis is squared per cycle on a shared multiplier.
	always_comb begin
		unique case (term_q)
			2'd0: sq_op = diff_q[0];
			2'd1: sq_op = diff_q[1];
			default: sq_op = diff_q[2];
		endcase
		sq_prod = sq_op * sq_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					term_q <= '0;
					state_q <= (mode == OP_EMIT) ? ST_PUSH : ST_SQUARE;
				end
				ST_SQUARE: begin
					term_q <= term_q + 2'd1;
					if (term_q == LAST_TERM) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: if (out_ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op <= mode;
			cmd_q.rpm <= engine_rpm;
			cmd_q.pos <= {src_z, src_y, src_x};
			cmd_q.vel <= {src_vz, src_vy, src_vx};
			cmd_q.sq_dist <= '0;
			diff_q[0] <= (COORD_W+1)'(src_x) - (COORD_W+1)'(lis_x);
			diff_q[1] <= (COORD_W+1)'(src_y) - (COORD_W+1)'(lis_y);
			diff_q[2] <= (COORD_W+1)'(src_z) - (COORD_W+1)'(lis_z);
			acc_q <= '0;
		end else if (state_q == ST_SQUARE) begin
			acc_q <= acc_q + DIST_W'(unsigned'(sq_prod));
		end
	end

endmodule

FILE: rtl/core/nsvs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsvs_queue
// Short command queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module nsvs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  nsvs_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output nsvs_pkg::cmd_t out_cmd
);
	import nsvs_pkg::*;

	cmd_t entry_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0] fill_q;
	logic push;
	logic pop;

	assign in_ready = (fill_q != (Q_PTR_W+1)'(QUEUE_DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_cmd = entry_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (Q_PTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (Q_PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

FILE: rtl/core/nsvs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsvs_back
// Slot table: appends, farthest-entry replacement scan and frame emission.
// ----------------------------------------------------------------------------
`include "nearest_source_voice_select_defines.svh"

module nsvs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [nsvs_pkg::CFG_W-1:0]   slot_count,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  nsvs_pkg::cmd_t               cmd,
	output logic                         res_valid,
	input  logic                         res_ready,
	output nsvs_pkg::res_t               res
);
	import nsvs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_WRITE = 3'd2;
	localparam logic [2:0] ST_EMIT_RD = 3'd3;
	localparam logic [2:0] ST_EMIT_WR = 3'd4;
	localparam logic [2:0] ST_EMPTY = 3'd5;

	localparam int VSUM_W = RPM_W - 1;
	localparam logic [VOL_W-1:0] VOL_BASE = VOL_W'(25);
	localparam logic [VOL_W-1:0] VOL_MAX = VOL_W'(75);
	localparam logic [FREQ_W-1:0] FREQ_BASE = FREQ_W'(2000);
	localparam logic [FREQ_W-1:0] FREQ_STEP = FREQ_W'(220);

	logic [2:0] state_q;
	logic [CNT_W-1:0] used_q;
	logic [DIST_W-1:0] far_q;
	cmd_t cur_q;

	logic [CNT_W-1:0] scan_rd_q;
	logic scan_pv_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic matched_q;
	logic [SLOT_W-1:0] match_idx_q;
	logic [DIST_W-1:0] max_q;
	logic [CNT_W-1:0] emit_idx_q;

	logic [DIST_W-1:0] dist_mem [MAX_SLOTS];
	entry_t entry_mem [MAX_SLOTS];
	logic [DIST_W-1:0] dist_rd_q;
	entry_t entry_rd_q;

	logic res_valid_q;
	res_t res_q;

	logic [CNT_W-1:0] cap;
	logic take;
	logic append;
	logic start_scan;
	logic scan_issue;
	logic scan_done;
	logic hit;
	logic [DIST_W-1:0] contrib;
	logic emit_issue;
	logic emit_last;
	logic res_free;
	logic emit_load;
	logic empty_load;
	logic wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [DIST_W-1:0] wr_dist;
	entry_t wr_entry;
	logic [VSUM_W-1:0] vol_sum;
	logic [VOL_W-1:0] volume;
	logic [FREQ_W-1:0] freq;

	assign cap = capacity(slot_count);
	assign cmd_ready = (state_q == ST_IDLE);
	assign take = cmd_valid && cmd_ready;
	assign append = take && (cmd.op == OP_ADD) && (used_q < cap);
	assign start_scan = take && (cmd.op == OP_ADD) && !(used_q < cap) && (cmd.sq_dist < far_q);

	assign scan_issue = (state_q == ST_SCAN) && (scan_rd_q < used_q);
	assign scan_done = (state_q == ST_SCAN) && !scan_issue && !scan_pv_q;
	assign hit = scan_pv_q && !matched_q && (scan_idx_q < cap) && (dist_rd_q == far_q);
	assign contrib = hit ? cur_q.sq_dist : dist_rd_q;

	assign emit_issue = (state_q == ST_EMIT_RD) && (used_q != '0);
	assign emit_last = (CNT_W'(emit_idx_q + CNT_W'(1)) == used_q);
	assign res_free = !res_valid_q || res_ready;
	assign emit_load = (state_q == ST_EMIT_WR) && res_free;
	assign empty_load = (state_q == ST_EMPTY) && res_free;

	always_comb begin
		wr_en = append || ((state_q == ST_WRITE) && matched_q);
		if (append) begin
			wr_addr = used_q[SLOT_W-1:0];
			wr_dist = cmd.sq_dist;
			wr_entry = '{rpm: cmd.rpm, pos: cmd.pos, vel: cmd.vel};
		end else begin
			wr_addr = match_idx_q;
			wr_dist = cur_q.sq_dist;
			wr_entry = '{rpm: cur_q.rpm, pos: cur_q.pos, vel: cur_q.vel};
		end
	end

	always_comb begin
		vol_sum = VSUM_W'(VOL_BASE) + VSUM_W'(entry_rd_q.rpm >> 2);
		volume = (vol_sum > VSUM_W'(VOL_MAX)) ? VOL_MAX : vol_sum[VOL_W-1:0];
		freq = FREQ_BASE + FREQ_W'(entry_rd_q.rpm) * FREQ_STEP;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dist_mem[wr_addr] <= wr_dist;
			entry_mem[wr_addr] <= wr_entry;
		end
		if (scan_issue) begin
			dist_rd_q <= dist_mem[scan_rd_q[SLOT_W-1:0]];
		end
		if (emit_issue) begin
			entry_rd_q <= entry_mem[emit_idx_q[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			far_q <= FAR_RESET;
			scan_rd_q <= '0;
			scan_pv_q <= 1'b0;
			scan_idx_q <= '0;
			matched_q <= 1'b0;
			match_idx_q <= '0;
			max_q <= '0;
			emit_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take) begin
					if (cmd.op == OP_EMIT) begin
						emit_idx_q <= '0;
						state_q <= ST_EMIT_RD;
					end else if (append) begin
						used_q <= used_q + CNT_W'(1);
						if ((used_q == '0) || (cmd.sq_dist > far_q)) begin
							far_q <= cmd.sq_dist;
						end
					end else if (start_scan) begin
						scan_rd_q <= '0;
						scan_pv_q <= 1'b0;
						matched_q <= 1'b0;
						max_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_pv_q <= scan_issue;
					scan_idx_q <= scan_rd_q;
					if (scan_issue) begin
						scan_rd_q <= scan_rd_q + CNT_W'(1);
					end
					if (scan_pv_q) begin
						if (contrib > max_q) begin
							max_q <= contrib;
						end
						if (hit) begin
							matched_q <= 1'b1;
							match_idx_q <= scan_idx_q[SLOT_W-1:0];
						end
					end
					if (scan_done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					far_q <= max_q;
					state_q <= ST_IDLE;
				end
				ST_EMIT_RD: state_q <= (used_q == '0) ? ST_EMPTY : ST_EMIT_WR;
				ST_EMIT_WR: if (res_free) begin
					if (emit_last) begin
						used_q <= '0;
						far_q <= FAR_RESET;
						state_q <= ST_IDLE;
					end else begin
						emit_idx_q <= emit_idx_q + CNT_W'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMPTY: if (res_free) begin
					far_q <= FAR_RESET;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load || empty_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_q.slot <= SLOT_OUT_W'(emit_idx_q);
			res_q.rpm <= entry_rd_q.rpm;
			res_q.pos <= entry_rd_q.pos;
			res_q.vel <= entry_rd_q.vel;
			res_q.volume <= volume;
			res_q.freq <= freq;
			res_q.present <= 1'b1;
			res_q.last <= emit_last;
		end else if (empty_load) begin
			res_q.slot <= '0;
			res_q.rpm <= '0;
			res_q.pos <= '0;
			res_q.vel <= '0;
			res_q.volume <= '0;
			res_q.freq <= '0;
			res_q.present <= 1'b0;
			res_q.last <= 1'b1;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`NSVS_ASSERT(a_used_in_range, clk, arst_n, used_q <= CNT_W'(MAX_SLOTS))
	`NSVS_IMPLY(a_hit_is_valid, clk, arst_n, hit, (scan_idx_q < cap) && (cur_q.sq_dist < far_q))
	`NSVS_NEXT(a_clear_after_last, clk, arst_n, emit_load && emit_last, (used_q == '0) && (far_q == FAR_RESET))

endmodule

FILE: rtl/core/nearest_source_voice_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_source_voice_select
// Keeps the nearest sound sources of a frame and emits them as voices.
// ----------------------------------------------------------------------------
// An add item (mode 0) brings a source and the listener position; the block
// keeps up to slot_count sources per frame, choosing those nearest to the
// listener by squared distance. Once the slots are full, a closer source
// replaces the first kept entry at the current farthest distance. An
// end-of-frame item (mode 1) emits every kept entry in slot order, with
// volume 25 + rpm/4 capped at 75 and frequency 2000 + rpm*220, marks the
// final one with last, and empties the table; an empty frame yields a single
// result with valid_res low and last high. For an add the front does three
// axis squarings on one shared multiplier; an end-of-frame item skips them.
// A two-entry queue then carries each item to the table logic. There an add
// into a free slot is written at once, and an add into a full table whose
// source is closer than the farthest kept entry starts a scan that reads one
// stored distance per cycle from the distance memory and then writes the
// chosen slot; any other source is dropped. An end of frame reads each
// kept entry through the registered read of the entry memory and loads it
// into the output register, waiting while the output is stalled. The front
// works on the next item while the table logic is busy. The slot memories
// are not cleared after reset: only entries below the kept count are ever
// read.
//
// Register map (APB, pready always high): byte address 0 holds slot_count,
// six bits, reset value 4; values above the storage size act as the size.
// Write it only while the block is idle.
// ----------------------------------------------------------------------------
module nearest_source_voice_select (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [9:0]           engine_rpm,
	input  logic signed [15:0]   src_x,
	input  logic signed [15:0]   src_y,
	input  logic signed [15:0]   src_z,
	input  logic signed [15:0]   src_vx,
	input  logic signed [15:0]   src_vy,
	input  logic signed [15:0]   src_vz,
	input  logic signed [15:0]   lis_x,
	input  logic signed [15:0]   lis_y,
	input  logic signed [15:0]   lis_z,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [4:0]           slot,
	output logic [9:0]           out_rpm,
	output logic signed [15:0]   out_x,
	output logic signed [15:0]   out_y,
	output logic signed [15:0]   out_z,
	output logic signed [15:0]   out_vx,
	output logic signed [15:0]   out_vy,
	output logic signed [15:0]   out_vz,
	output logic [6:0]           voice_volume,
	output logic [17:0]          voice_freq,
	output logic                 valid_res,
	output logic                 last
);
	import nsvs_pkg::*;

	// The register index is the word address; there is a single register.
	localparam logic REG_SLOT_COUNT = 1'b0;

	logic [CFG_W-1:0] slot_count_q;
	logic cfg_write;

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t queue_cmd;
	logic queue_valid;
	logic queue_ready;
	res_t res;

	// Configuration: a write lands in the access phase of the transfer.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SLOT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RESET;
		end else if (cfg_write) begin
			slot_count_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SLOT_COUNT) begin
			prdata = 32'(slot_count_q);
		end
	end

	// Front: takes items and forms the squared distance of each source.
	nsvs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.engine_rpm (engine_rpm),
		.src_x      (src_x),
		.src_y      (src_y),
		.src_z      (src_z),
		.src_vx     (src_vx),
		.src_vy     (src_vy),
		.src_vz     (src_vz),
		.lis_x      (lis_x),
		.lis_y      (lis_y),
		.lis_z      (lis_z),
		.out_valid  (front_valid),
		.out_ready  (front_ready),
		.out_cmd    (front_cmd)
	);

	// The queue decouples the two halves so that each may stall alone.
	nsvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (queue_valid),
		.out_ready (queue_ready),
		.out_cmd   (queue_cmd)
	);

	// Back: owns the slot table and the output register.
	nsvs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_count (slot_count_q),
		.cmd_valid  (queue_valid),
		.cmd_ready  (queue_ready),
		.cmd        (queue_cmd),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	// The position and velocity words pack x in the lowest lane.
	assign slot = res.slot;
	assign out_rpm = res.rpm;
	assign out_x = res.pos[0];
	assign out_y = res.pos[1];
	assign out_z = res.pos[2];
	assign out_vx = res.vel[0];
	assign out_vy = res.vel[1];
	assign out_vz = res.vel[2];
	assign voice_volume = res.volume;
	assign voice_freq = res.freq;
	assign valid_res = res.present;
	assign last = res.last;

endmodule

FILE: tb/nsvs_voice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsvs_voice_checker
// Watches the ports of the voice select block, predicts every voice it should
// emit and compares each emitted voice with the oldest prediction.
// ----------------------------------------------------------------------------

package nsvs_tb_pkg;

	localparam int REG_SLOT_COUNT = 0;
	localparam int APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] SLOT_COUNT_ADDR = APB_ADDR_W'(4 * REG_SLOT_COUNT);

endpackage

module nsvs_voice_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	input  logic [31:0]          prdata,
	input  logic                 pready,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 mode,
	input  logic [9:0]           engine_rpm,
	input  logic signed [15:0]   src_x,
	input  logic signed [15:0]   src_y,
	input  logic signed [15:0]   src_z,
	input  logic signed [15:0]   src_vx,
	input  logic signed [15:0]   src_vy,
	input  logic signed [15:0]   src_vz,
	input  logic signed [15:0]   lis_x,
	input  logic signed [15:0]   lis_y,
	input  logic signed [15:0]   lis_z,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [4:0]           slot,
	input  logic [9:0]           out_rpm,
	input  logic signed [15:0]   out_x,
	input  logic signed [15:0]   out_y,
	input  logic signed [15:0]   out_z,
	input  logic signed [15:0]   out_vx,
	input  logic signed [15:0]   out_vy,
	input  logic signed [15:0]   out_vz,
	input  logic [6:0]           voice_volume,
	input  logic [17:0]          voice_freq,
	input  logic                 valid_res,
	input  logic                 last,
	output int                   mismatches,
	output int                   outstanding
);

	import nsvs_pkg::*;
	import nsvs_tb_pkg::*;

	localparam int VOLUME_BASE = 25;
	localparam int VOLUME_CAP = 75;
	localparam int FREQ_BASE = 2000;
	localparam int FREQ_STEP = 220;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic [RPM_W-1:0] rpm;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] vx;
		logic [COORD_W-1:0] vy;
		logic [COORD_W-1:0] vz;
		logic [VOL_W-1:0] volume;
		logic [FREQ_W-1:0] freq;
		logic present;
		logic is_last;
	} voice_t;

	// Kept sources of the open frame.
	logic [RPM_W-1:0] kept_rpm [MAX_SLOTS];
	logic [3*COORD_W-1:0] kept_pos [MAX_SLOTS];
	logic [3*COORD_W-1:0] kept_vel [MAX_SLOTS];
	logic [DIST_W-1:0] kept_dist [MAX_SLOTS];
	int kept_n;
	logic [DIST_W-1:0] farthest;
	logic [CFG_W-1:0] slot_count_q;

	voice_t voices_due [$];
	voice_t got;
	voice_t want;
	voice_t v;
	int errors = 0;
	int cap;
	int level;
	logic hit;
	logic [DIST_W-1:0] d;
	longint dx;
	longint dy;
	longint dz;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic string describe(input voice_t x);
		return $sformatf("slot %0d rpm %0d pos (%0d,%0d,%0d) vel (%0d,%0d,%0d) vol %0d freq %0d valid %0b last %0b",
			x.slot, x.rpm, $signed(x.x), $signed(x.y), $signed(x.z),
			$signed(x.vx), $signed(x.vy), $signed(x.vz), x.volume, x.freq, x.present, x.is_last);
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	task automatic keep_source(input int i);
		kept_rpm[i] = engine_rpm;
		kept_pos[i] = {src_x, src_y, src_z};
		kept_vel[i] = {src_vx, src_vy, src_vz};
		kept_dist[i] = d;
	endtask

	task automatic refresh_farthest();
		farthest = '0;
		for (int i = 0; i < kept_n; i++) begin
			if (kept_dist[i] > farthest) begin
				farthest = kept_dist[i];
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q = SLOT_COUNT_RESET;
			kept_n = 0;
			farthest = FAR_RESET;
			voices_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = {slot, out_rpm, out_x, out_y, out_z, out_vx, out_vy, out_vz,
					voice_volume, voice_freq, valid_res, last};
				if (voices_due.size() == 0) begin
					report({"unexpected voice: ", describe(got)});
				end else begin
					want = voices_due.pop_front();
					if (got !== want) begin
						report({"expected ", describe(want), " got ", describe(got)});
					end
				end
			end

			if (in_valid && in_ready) begin
				cap = (slot_count_q < MAX_SLOTS) ? int'(slot_count_q) : MAX_SLOTS;
				if (mode == OP_ADD) begin
					dx = longint'(src_x) - longint'(lis_x);
					dy = longint'(src_y) - longint'(lis_y);
					dz = longint'(src_z) - longint'(lis_z);
					d = DIST_W'(dx * dx + dy * dy + dz * dz);
					if (kept_n < cap) begin
						keep_source(kept_n);
						kept_n++;
						refresh_farthest();
					end else if (d < farthest) begin
						// Only slots below the current slot count are scanned.
						hit = 1'b0;
						for (int i = 0; i < cap; i++) begin
							if (!hit && kept_dist[i] == farthest) begin
								keep_source(i);
								hit = 1'b1;
							end
						end
						refresh_farthest();
					end
				end else begin
					if (kept_n == 0) begin
						v = '0;
						v.is_last = 1'b1;
						voices_due.push_back(v);
					end else begin
						for (int i = 0; i < kept_n; i++) begin
							v = '0;
							v.slot = SLOT_OUT_W'(i);
							v.rpm = kept_rpm[i];
							{v.x, v.y, v.z} = kept_pos[i];
							{v.vx, v.vy, v.vz} = kept_vel[i];
							level = VOLUME_BASE + int'(kept_rpm[i]) / 4;
							if (level > VOLUME_CAP) begin
								level = VOLUME_CAP;
							end
							v.volume = VOL_W'(level);
							v.freq = FREQ_W'(FREQ_BASE + FREQ_STEP * int'(kept_rpm[i]));
							v.present = 1'b1;
							v.is_last = (i == kept_n - 1);
							voices_due.push_back(v);
						end
					end
					kept_n = 0;
					farthest = FAR_RESET;
				end
			end

			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == SLOT_COUNT_ADDR) begin
						slot_count_q = pwdata[CFG_W-1:0];
					end
				end else if (paddr == SLOT_COUNT_ADDR && prdata[CFG_W-1:0] !== slot_count_q) begin
					report($sformatf("slot_count read %0d, expected %0d",
						prdata[CFG_W-1:0], slot_count_q));
				end
			end
		end
		mismatches <= errors;
		outstanding <= voices_due.size();
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the nearest source voice select block: a directed
// opening, then random frames over several slot counts and idling profiles.
// ----------------------------------------------------------------------------

module tb;

	import nsvs_pkg::*;
	import nsvs_tb_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 9;
	// An add into a full table scans every kept entry and up to three
	// items may be queued inside the block, so this covers the slowest case.
	localparam int SETTLE_CYCLES = 150;
	localparam int TIMEOUT_NS = 20_000_000;
	// Random frames share this budget; the directed opening and the frames
	// left open between phases bring the whole run to about four hundred items.
	localparam int RANDOM_ITEMS = 250;
	localparam int PHASES = 10;

	typedef enum int {SPREAD_NEAR, SPREAD_WIDE, SPREAD_EDGE} spread_e;

	// One input item as it is put on the input channel.
	typedef struct packed {
		logic op;
		logic [RPM_W-1:0] rpm;
		logic [3*COORD_W-1:0] pos;
		logic [3*COORD_W-1:0] vel;
		logic [3*COORD_W-1:0] listener;
	} source_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic [9:0] engine_rpm = '0;
	logic signed [15:0] src_x = '0;
	logic signed [15:0] src_y = '0;
	logic signed [15:0] src_z = '0;
	logic signed [15:0] src_vx = '0;
	logic signed [15:0] src_vy = '0;
	logic signed [15:0] src_vz = '0;
	logic signed [15:0] lis_x = '0;
	logic signed [15:0] lis_y = '0;
	logic signed [15:0] lis_z = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] slot;
	logic [9:0] out_rpm;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;
	logic signed [15:0] out_vx;
	logic signed [15:0] out_vy;
	logic signed [15:0] out_vz;
	logic [6:0] voice_volume;
	logic [17:0] voice_freq;
	logic valid_res;
	logic last;

	int mismatches;
	int outstanding;

	// Chance in a hundred, per cycle, of the sender idling and the receiver
	// stalling. Both are changed only between phases.
	int gap_pct = 0;
	int stall_pct = 0;
	int sent = 0;

	nearest_source_voice_select dut (.*);

	nsvs_voice_checker voice_check (.*);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// The receiver decides afresh every cycle whether to take a voice.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Safety net: a hung handshake must not keep the run going for ever.
	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic spread_e pick_spread();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60) begin
			return SPREAD_NEAR;
		end else if (roll < 85) begin
			return SPREAD_WIDE;
		end
		return SPREAD_EDGE;
	endfunction

	// Near values cluster round the origin so that equal distances, and so
	// ties at the farthest kept entry, turn up often.
	function automatic logic [COORD_W-1:0] pick_coord(input spread_e spread);
		int t;
		case (spread)
			SPREAD_NEAR: begin
				t = $urandom_range(12);
				return COORD_W'(t - 6);
			end
			SPREAD_WIDE: begin
				return COORD_W'($urandom);
			end
			default: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
		endcase
	endfunction

	function automatic logic [3*COORD_W-1:0] pick_point();
		spread_e s;
		s = pick_spread();
		return {pick_coord(s), pick_coord(s), pick_coord(s)};
	endfunction

	function automatic source_item_t random_source(input logic [3*COORD_W-1:0] listener);
		source_item_t it;
		it.op = OP_ADD;
		it.rpm = RPM_W'($urandom);
		it.pos = pick_point();
		it.vel = {pick_coord(SPREAD_WIDE), pick_coord(SPREAD_WIDE), pick_coord(SPREAD_WIDE)};
		it.listener = listener;
		return it;
	endfunction

	// Puts one item on the input channel, after a random gap, and returns at
	// the edge at which it is taken. Valid is left high so that a following
	// item can go out back to back.
	task automatic drive_item(input source_item_t it);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.op;
		engine_rpm <= it.rpm;
		{src_x, src_y, src_z} <= it.pos;
		{src_vx, src_vy, src_vz} <= it.vel;
		{lis_x, lis_y, lis_z} <= it.listener;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sent++;
	endtask

	task automatic add_source(input logic [RPM_W-1:0] rpm, input logic [3*COORD_W-1:0] pos,
			input logic [3*COORD_W-1:0] vel, input logic [3*COORD_W-1:0] listener);
		source_item_t it;
		it.op = OP_ADD;
		it.rpm = rpm;
		it.pos = pos;
		it.vel = vel;
		it.listener = listener;
		drive_item(it);
	endtask

	// The rest of an end-of-frame item is ignored by the block, so it carries
	// random content.
	task automatic end_frame();
		source_item_t it;
		logic [159:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = noise[$bits(source_item_t)-1:0];
		it.op = OP_EMIT;
		drive_item(it);
	endtask

	// One transfer on the register port: a setup phase, an access phase, and
	// a step with the port released.
	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes slot_count and reads it back; the checker follows both.
	task automatic set_slot_count(input int count);
		apb_access(1'b1, SLOT_COUNT_ADDR, 32'(count));
		apb_access(1'b0, SLOT_COUNT_ADDR, '0);
	endtask

	// Waits until every predicted voice has come out, then lets the block
	// finish any add that is still working its way through the table.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A well-formed frame: a handful of adds round one listener, now and then
	// one that moves, then the end of the frame. Most frames stay small; a few
	// fill every slot and spill over so that replacement is exercised.
	task automatic run_frame(input int cap);
		logic [3*COORD_W-1:0] listener;
		int n_adds;
		listener = pick_point();
		if ($urandom_range(9) == 0) begin
			n_adds = $urandom_range(cap + 4);
		end else begin
			n_adds = $urandom_range(((cap < 6) ? cap : 6) + 3);
		end
		repeat (n_adds) begin
			if ($urandom_range(99) < 15) begin
				listener = pick_point();
			end
			drive_item(random_source(listener));
		end
		end_frame();
	endtask

	function automatic int slots_for_phase(input int p);
		case (p)
			0: return 32;
			1: return 2;
			2: return 0;
			3: return 63;
			4: return 1;
			5: return 33;
			6: return 5;
			7: return 32;
			8: return 3;
			default: return 7;
		endcase
	endfunction

	initial begin
		int cap;
		int budget;
		logic [3*COORD_W-1:0] listener;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The register must come out of reset at four slots.
		apb_access(1'b0, SLOT_COUNT_ADDR, '0);

		// Directed opening with four slots and no idling. An end of frame on
		// an empty table yields the lone empty marker.
		end_frame();
		// Opposite corners of the space give the largest squared distance
		// twice over, with extreme velocities and engine speeds.
		add_source(10'd0, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h7fff}});
		add_source(10'd1023, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h8000}});
		// A source on top of the listener, and speeds either side of the
		// point where the volume reaches its cap.
		add_source(10'd199, {16'd100, 16'hff9c, 16'd5}, '0, {16'd100, 16'hff9c, 16'd5});
		add_source(10'd200, {16'd3, 16'd4, 16'd0}, {16'h0001, 16'hfffe, 16'h0003}, '0);
		// The table is full. A source level with the farthest is not kept.
		add_source(10'd203, {3{16'h7fff}}, '0, {3{16'h8000}});
		// Closer sources replace the first entry at the farthest distance;
		// a tie with the new farthest is turned away.
		add_source(10'd803, {16'd10, 16'd0, 16'd0}, '0, '0);
		add_source(10'd1, {16'd0, 16'd10, 16'd0}, {3{16'h5555}}, '0);
		add_source(10'd2, {16'd0, 16'd0, 16'd10}, {3{16'haaaa}}, '0);
		add_source(10'd4, {16'd1, 16'd0, 16'd0}, '0, '0);
		end_frame();
		// A frame of one voice, which is also the last of its frame.
		add_source(10'd5, {16'hffff, 16'h0001, 16'h8000}, '0, {16'h0001, 16'hffff, 16'h8000});
		end_frame();

		// Random frames. Each phase moves to a new slot count and idling
		// profile. Where the next count is lower, the frame is left open so
		// that the count drops while entries are kept above it.
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 49;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 49;
				end
				default: begin
					gap_pct = 35;
					stall_pct = 35;
				end
			endcase
			set_slot_count(slots_for_phase(phase));
			cap = (slots_for_phase(phase) < MAX_SLOTS) ? slots_for_phase(phase) : MAX_SLOTS;
			budget = sent + RANDOM_ITEMS / PHASES;
			while (sent < budget) begin
				run_frame(cap);
			end
			if (slots_for_phase(phase) > slots_for_phase((phase + 1) % PHASES)) begin
				listener = pick_point();
				repeat (cap + $urandom_range(3)) begin
					drive_item(random_source(listener));
				end
			end
		end
		end_frame();
		settle();

		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: nearest_source_voice_select.f
+incdir+rtl/core
rtl/core/nsvs_pkg.sv
rtl/core/nsvs_front.sv
rtl/core/nsvs_queue.sv
rtl/core/nsvs_back.sv
rtl/core/nearest_source_voice_select.sv
tb/nsvs_voice_checker.sv
tb/tb.sv
